/* rtl/tcw_pkg.sv */
// Shared types and codes of the text console writer.
// Used by tcw_seq and by the top level text_console_writer_core; depends on nothing.
`default_nettype none

package tcw_pkg;

    // Fixed field widths of the item and result beats.
    localparam int BYTE_W    = 8;
    localparam int OP_W      = 3;
    localparam int POS_W     = 7;
    localparam int ADDR_IN_W = 11;
    localparam int ROW_W     = 5;
    localparam int COL_OUT_W = 7;
    localparam int CELL_W    = 2 * BYTE_W;

    // Operation codes. Codes 6 and 7 are unused and only report the cursor.
    localparam logic [OP_W-1:0] OP_PUT_CHAR = 3'd0;
    localparam logic [OP_W-1:0] OP_CLEAR    = 3'd1;
    localparam logic [OP_W-1:0] OP_SET_ROW  = 3'd2;
    localparam logic [OP_W-1:0] OP_SET_COL  = 3'd3;
    localparam logic [OP_W-1:0] OP_ERASE    = 3'd4;
    localparam logic [OP_W-1:0] OP_READ     = 3'd5;

    // Configuration register indexes.
    localparam logic CFG_TEXT_COLOR  = 1'b0;
    localparam logic CFG_ERASE_FLOOR = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [BYTE_W-1:0] TEXT_COLOR_RST  = 8'd15;
    localparam logic [POS_W-1:0]  ERASE_FLOOR_RST = 7'd7;

    // Character codes.
    localparam logic [BYTE_W-1:0] NEWLINE_CODE = 8'd10;
    localparam logic [BYTE_W-1:0] BLANK_CODE   = 8'd32;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_RDATA,
        ST_SCROLL,
        ST_SDRAIN,
        ST_BLANK,
        ST_CLEAR,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [OP_W-1:0]      operation;
        logic [BYTE_W-1:0]    char_code;
        logic                 use_fill_color;
        logic [BYTE_W-1:0]    fill_color;
        logic [POS_W-1:0]     position;
        logic [ADDR_IN_W-1:0] cell_address;
    } t_item;

    typedef struct packed {
        logic [BYTE_W-1:0] text_color;
        logic [POS_W-1:0]  erase_floor;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0]    cell_char;
        logic [BYTE_W-1:0]    cell_color;
        logic [ROW_W-1:0]     cursor_row;
        logic [COL_OUT_W-1:0] cursor_col;
    } t_result;

endpackage

`default_nettype wire

/* rtl/text_console_writer_core.sv */
// Top level of the text console writer: ports, configuration registers,
// output register. Depends on tcw_pkg, tcw_seq and tcw_ram.
`default_nettype none

// Text console over a ROWS x COLUMNS grid of character cells kept in one
// single-write-port memory. Every input beat gives exactly one result beat.
// Set row, set column, erase back, a character write, a newline off the last
// row and the unused codes give their result from the execute state. A character
// written to a full row that is not the last wraps first and is written later,
// because the wrap and the write are separate cycles. A cell read passes a further
// state because the memory read is registered. A newline or wrap on the last row
// scrolls the grid one cell per cycle through the memory port and then blanks the
// bottom row. Clear screen writes a blank to every cell. After reset a clearing
// pass zeroes the memory; during it o_in_stall is high, while configuration writes
// are taken as usual. The output register holds one finished result, so the
// next beat is taken while the previous result waits on i_out_stall.
module text_console_writer_core #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Configuration port.
    input  wire logic                              i_cfg_we,
    input  wire logic                              i_cfg_index,
    input  wire logic [tcw_pkg::BYTE_W-1:0]        i_cfg_data,
    // Item channel.
    input  wire logic                              i_in_valid,
    output logic                                   o_in_stall,
    input  wire logic [tcw_pkg::OP_W-1:0]          i_operation,
    input  wire logic [tcw_pkg::BYTE_W-1:0]        i_char_code,
    input  wire logic                              i_use_fill_color,
    input  wire logic [tcw_pkg::BYTE_W-1:0]        i_fill_color,
    input  wire logic [tcw_pkg::POS_W-1:0]         i_position,
    input  wire logic [tcw_pkg::ADDR_IN_W-1:0]     i_cell_address,
    // Result channel.
    output logic                                   o_out_valid,
    input  wire logic                              i_out_stall,
    output logic [tcw_pkg::BYTE_W-1:0]             o_cell_char,
    output logic [tcw_pkg::BYTE_W-1:0]             o_cell_color,
    output logic [tcw_pkg::ROW_W-1:0]              o_cursor_row,
    output logic [tcw_pkg::COL_OUT_W-1:0]          o_cursor_col
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int AW    = $clog2(CELLS);

    tcw_pkg::t_cfg    r_cfg;
    tcw_pkg::t_item   w_item;
    tcw_pkg::t_result w_res;
    tcw_pkg::t_result r_out;
    logic             r_out_valid;
    logic             w_out_free;
    logic             w_busy;
    logic             w_res_valid;
    logic             w_start;

    logic                       w_ram_we;
    logic [AW-1:0]              w_ram_waddr;
    logic [tcw_pkg::CELL_W-1:0] w_ram_wdata;
    logic [AW-1:0]              w_ram_raddr;
    logic [tcw_pkg::CELL_W-1:0] w_ram_rdata;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.text_color  <= tcw_pkg::TEXT_COLOR_RST;
            r_cfg.erase_floor <= tcw_pkg::ERASE_FLOOR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tcw_pkg::CFG_TEXT_COLOR:  r_cfg.text_color  <= i_cfg_data;
                tcw_pkg::CFG_ERASE_FLOOR: r_cfg.erase_floor <= i_cfg_data[tcw_pkg::POS_W-1:0];
                default: ;
            endcase
        end
    end

    // Item beat.
    assign w_item.operation      = i_operation;
    assign w_item.char_code      = i_char_code;
    assign w_item.use_fill_color = i_use_fill_color;
    assign w_item.fill_color     = i_fill_color;
    assign w_item.position       = i_position;
    assign w_item.cell_address   = i_cell_address;

    assign o_in_stall = w_busy;
    assign w_start    = i_in_valid && !w_busy;
    assign w_out_free = !r_out_valid || !i_out_stall;

    tcw_seq #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS),
        .AW      (AW)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_item      (w_item),
        .i_cfg       (r_cfg),
        .i_out_free  (w_out_free),
        .o_busy      (w_busy),
        .o_res_valid (w_res_valid),
        .o_res       (w_res),
        .o_ram_we    (w_ram_we),
        .o_ram_waddr (w_ram_waddr),
        .o_ram_wdata (w_ram_wdata),
        .o_ram_raddr (w_ram_raddr),
        .i_ram_rdata (w_ram_rdata)
    );

    tcw_ram #(
        .WIDTH (tcw_pkg::CELL_W),
        .DEPTH (CELLS)
    ) u_cells (
        .i_clk   (i_clk),
        .i_we    (w_ram_we),
        .i_waddr (w_ram_waddr),
        .i_wdata (w_ram_wdata),
        .i_raddr (w_ram_raddr),
        .o_rdata (w_ram_rdata)
    );

    // Output register: holds one result beat until it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_cell_char  = r_out.cell_char;
    assign o_cell_color = r_out.cell_color;
    assign o_cursor_row = r_out.cursor_row;
    assign o_cursor_col = r_out.cursor_col;

endmodule

`default_nettype wire

/* rtl/tcw_ram.sv */
// Generic simple dual-port RAM: one write port and one registered read port.
// Depends on nothing; holds the character cells of the console.
`default_nettype none

module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* rtl/tcw_seq.sv */
// Operation sequencer of the text console writer: cursor, scroll and clear walks,
// and the cell memory port control. Depends on tcw_pkg; drives one tcw_ram.
`default_nettype none

module tcw_seq #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25,
    parameter int AW      = 11
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    input  wire tcw_pkg::t_item       i_item,
    input  wire tcw_pkg::t_cfg        i_cfg,
    input  wire logic                 i_out_free,
    output logic                      o_busy,
    output logic                      o_res_valid,
    output tcw_pkg::t_result          o_res,
    output logic                      o_ram_we,
    output logic [AW-1:0]             o_ram_waddr,
    output logic [tcw_pkg::CELL_W-1:0] o_ram_wdata,
    output logic [AW-1:0]             o_ram_raddr,
    input  wire logic [tcw_pkg::CELL_W-1:0] i_ram_rdata
);

    localparam int CELLS = ROWS * COLUMNS;
    localparam int CW    = $clog2(COLUMNS + 1);

    localparam logic [AW-1:0] LAST_CELL = AW'(CELLS - 1);
    localparam logic [AW-1:0] ROW_SPAN  = AW'(COLUMNS);
    localparam logic [AW-1:0] LAST_ROW0 = AW'((ROWS - 1) * COLUMNS);

    tcw_pkg::t_state          r_state, n_state;
    tcw_pkg::t_item           r_item, n_item;
    logic [tcw_pkg::ROW_W-1:0] r_row, n_row;
    logic [CW-1:0]            r_col, n_col;
    logic [AW-1:0]            r_ptr, n_ptr;
    logic                     r_wpend, n_wpend;
    logic [AW-1:0]            r_waddr, n_waddr;
    logic                     r_after_char, n_after_char;
    logic [tcw_pkg::BYTE_W-1:0] r_fill, n_fill;

    logic [AW-1:0]            w_base;
    logic [AW-1:0]            w_cur_addr;
    logic                     w_not_last_row;
    logic                     w_in_range;

    // Cell address of the cursor.
    assign w_base         = AW'(r_row) * ROW_SPAN;
    assign w_cur_addr     = w_base + AW'(r_col);
    assign w_not_last_row = r_row < tcw_pkg::ROW_W'(ROWS - 1);
    assign w_in_range     = 32'(r_item.cell_address) < 32'(CELLS);

    assign o_busy = (r_state != tcw_pkg::ST_IDLE);

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= tcw_pkg::ST_INIT;
            r_row        <= '0;
            r_col        <= '0;
            r_ptr        <= '0;
            r_wpend      <= 1'b0;
            r_after_char <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_row        <= n_row;
            r_col        <= n_col;
            r_ptr        <= n_ptr;
            r_wpend      <= n_wpend;
            r_after_char <= n_after_char;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_item  <= n_item;
        r_waddr <= n_waddr;
        r_fill  <= n_fill;
    end

    // Next state, memory port and result.
    always_comb begin
        n_state      = r_state;
        n_item       = r_item;
        n_row        = r_row;
        n_col        = r_col;
        n_ptr        = r_ptr;
        n_wpend      = 1'b0;
        n_waddr      = r_waddr;
        n_after_char = r_after_char;
        n_fill       = r_fill;

        o_ram_we     = 1'b0;
        o_ram_waddr  = r_ptr;
        o_ram_wdata  = {i_cfg.text_color, tcw_pkg::BLANK_CODE};
        o_ram_raddr  = r_ptr;

        o_res_valid  = 1'b0;
        o_res        = '0;

        // A pending scroll copy writes the cell read in the previous cycle.
        if (r_wpend) begin
            o_ram_we    = 1'b1;
            o_ram_waddr = r_waddr;
            o_ram_wdata = i_ram_rdata;
        end

        unique case (r_state)
            tcw_pkg::ST_INIT: begin
                // Clearing pass after reset: every cell to zero.
                o_ram_we    = 1'b1;
                o_ram_wdata = '0;
                if (r_ptr == LAST_CELL) begin
                    n_ptr   = '0;
                    n_state = tcw_pkg::ST_IDLE;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end

            tcw_pkg::ST_IDLE: begin
                if (i_start) begin
                    n_item  = i_item;
                    n_state = tcw_pkg::ST_EXEC;
                end
            end

            tcw_pkg::ST_EXEC: begin
                o_ram_raddr = AW'(r_item.cell_address);
                unique case (r_item.operation)
                    tcw_pkg::OP_PUT_CHAR: begin
                        if (r_item.char_code == tcw_pkg::NEWLINE_CODE) begin
                            if (w_not_last_row) begin
                                if (i_out_free) begin
                                    n_row       = r_row + 1'b1;
                                    n_col       = '0;
                                    o_res_valid = 1'b1;
                                    n_state     = tcw_pkg::ST_IDLE;
                                end
                            end else begin
                                n_col        = '0;
                                n_after_char = 1'b0;
                                n_ptr        = ROW_SPAN;
                                n_state      = tcw_pkg::ST_SCROLL;
                            end
                        end else if (32'(r_col) >= 32'(COLUMNS)) begin
                            // Row full: wrap first, then write on a later cycle.
                            n_col = '0;
                            if (w_not_last_row) begin
                                n_row = r_row + 1'b1;
                            end else begin
                                n_after_char = 1'b1;
                                n_ptr        = ROW_SPAN;
                                n_state      = tcw_pkg::ST_SCROLL;
                            end
                        end else if (i_out_free) begin
                            o_ram_we    = 1'b1;
                            o_ram_waddr = w_cur_addr;
                            o_ram_wdata = {i_cfg.text_color, r_item.char_code};
                            n_col       = r_col + 1'b1;
                            o_res_valid = 1'b1;
                            n_state     = tcw_pkg::ST_IDLE;
                        end
                    end
                    tcw_pkg::OP_CLEAR: begin
                        n_fill  = r_item.use_fill_color ? r_item.fill_color
                                                        : i_cfg.text_color;
                        n_ptr   = '0;
                        n_state = tcw_pkg::ST_CLEAR;
                    end
                    tcw_pkg::OP_SET_ROW: begin
                        if (i_out_free) begin
                            n_row = (r_item.position > tcw_pkg::POS_W'(ROWS - 1))
                                  ? tcw_pkg::ROW_W'(ROWS - 1)
                                  : tcw_pkg::ROW_W'(r_item.position);
                            o_res_valid = 1'b1;
                            n_state     = tcw_pkg::ST_IDLE;
                        end
                    end
                    tcw_pkg::OP_SET_COL: begin
                        if (i_out_free) begin
                            n_col = (r_item.position > tcw_pkg::POS_W'(COLUMNS - 1))
                                  ? CW'(COLUMNS - 1)
                                  : CW'(r_item.position);
                            o_res_valid = 1'b1;
                            n_state     = tcw_pkg::ST_IDLE;
                        end
                    end
                    tcw_pkg::OP_ERASE: begin
                        if (i_out_free) begin
                            if (8'(r_col) > 8'(i_cfg.erase_floor)) begin
                                o_ram_we    = 1'b1;
                                o_ram_waddr = w_cur_addr - 1'b1;
                                n_col       = r_col - 1'b1;
                            end
                            o_res_valid = 1'b1;
                            n_state     = tcw_pkg::ST_IDLE;
                        end
                    end
                    tcw_pkg::OP_READ: begin
                        n_state = tcw_pkg::ST_RDATA;
                    end
                    default: begin
                        if (i_out_free) begin
                            o_res_valid = 1'b1;
                            n_state     = tcw_pkg::ST_IDLE;
                        end
                    end
                endcase
            end

            tcw_pkg::ST_RDATA: begin
                // Hold the read address so the read data stays put while stalled.
                o_ram_raddr = AW'(r_item.cell_address);
                if (i_out_free) begin
                    if (w_in_range) begin
                        o_res.cell_char  = i_ram_rdata[tcw_pkg::BYTE_W-1:0];
                        o_res.cell_color = i_ram_rdata[tcw_pkg::CELL_W-1:tcw_pkg::BYTE_W];
                    end
                    o_res_valid = 1'b1;
                    n_state     = tcw_pkg::ST_IDLE;
                end
            end

            tcw_pkg::ST_SCROLL: begin
                // Read one cell and copy it one row up on the next cycle.
                n_wpend = 1'b1;
                n_waddr = r_ptr - ROW_SPAN;
                if (r_ptr == LAST_CELL) begin
                    n_state = tcw_pkg::ST_SDRAIN;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end

            tcw_pkg::ST_SDRAIN: begin
                n_ptr   = LAST_ROW0;
                n_state = tcw_pkg::ST_BLANK;
            end

            tcw_pkg::ST_BLANK: begin
                // Blank the bottom row in the text color.
                o_ram_we = 1'b1;
                if (r_ptr == LAST_CELL) begin
                    n_state = r_after_char ? tcw_pkg::ST_EXEC : tcw_pkg::ST_FINISH;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end

            tcw_pkg::ST_CLEAR: begin
                o_ram_we    = 1'b1;
                o_ram_wdata = {r_fill, tcw_pkg::BLANK_CODE};
                if (r_ptr == LAST_CELL) begin
                    n_row   = '0;
                    n_col   = '0;
                    n_state = tcw_pkg::ST_FINISH;
                end else begin
                    n_ptr = r_ptr + 1'b1;
                end
            end

            tcw_pkg::ST_FINISH: begin
                if (i_out_free) begin
                    o_res_valid = 1'b1;
                    n_state     = tcw_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = tcw_pkg::ST_IDLE;
            end
        endcase

        o_res.cursor_row = n_row;
        o_res.cursor_col = tcw_pkg::COL_OUT_W'(n_col);
    end

    // A result is only offered when the output register can take it.
    a_res_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> i_out_free)
        else $error("result offered while output register is full");

    // The cursor row stays on the grid.
    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_row) < ROWS)
        else $error("cursor row beyond last row");

    // The cursor column reaches at most the column count (row full).
    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_col) <= COLUMNS)
        else $error("cursor column beyond column count");

    // A copy write is only pending right after a scroll read.
    a_copy_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wpend |-> $past(r_state == tcw_pkg::ST_SCROLL))
        else $error("copy write without scroll read");

endmodule

`default_nettype wire

/* verif/text_console_writer_checker.sv */
// Checker for text_console_writer_core: watches the item, result and register ports,
// predicts every result and compares it. Depends on tcw_pkg only.

module text_console_writer_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_we,
    input  wire logic                          i_cfg_index,
    input  wire logic [tcw_pkg::BYTE_W-1:0]    i_cfg_data,
    input  wire logic                          i_in_valid,
    input  wire logic                          i_in_stall,
    input  wire logic [tcw_pkg::OP_W-1:0]      i_operation,
    input  wire logic [tcw_pkg::BYTE_W-1:0]    i_char_code,
    input  wire logic                          i_use_fill_color,
    input  wire logic [tcw_pkg::BYTE_W-1:0]    i_fill_color,
    input  wire logic [tcw_pkg::POS_W-1:0]     i_position,
    input  wire logic [tcw_pkg::ADDR_IN_W-1:0] i_cell_address,
    input  wire logic                          i_out_valid,
    input  wire logic                          i_out_stall,
    input  wire logic [tcw_pkg::BYTE_W-1:0]    i_cell_char,
    input  wire logic [tcw_pkg::BYTE_W-1:0]    i_cell_color,
    input  wire logic [tcw_pkg::ROW_W-1:0]     i_cursor_row,
    input  wire logic [tcw_pkg::COL_OUT_W-1:0] i_cursor_col,
    output int                                 o_fail_count,
    output int                                 o_pending,
    output int                                 o_scrolls,
    output int                                 o_checked
);

    import tcw_pkg::*;

    localparam int CELLS = ROWS * COLUMNS;

    // Shadow copy of the screen, the cursor and the two registers.
    logic [CELL_W-1:0]    grid [CELLS];
    logic [ROW_W-1:0]     cur_row;
    logic [COL_OUT_W-1:0] cur_col;
    logic [BYTE_W-1:0]    ink_color;
    logic [POS_W-1:0]     floor_col;

    t_result expected_results [$];
    int      mismatches   = 0;
    int      scroll_count = 0;
    int      compared     = 0;
    int      pending_n    = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = pending_n;
    assign o_scrolls    = scroll_count;
    assign o_checked    = compared;

    task automatic flag_error(input string msg);
        $display("[%0t] console check: %s", $time, msg);
        mismatches++;
    endtask

    task automatic blank_row(input int row, input logic [BYTE_W-1:0] colr);
        for (int c = 0; c < COLUMNS; c++) begin
            grid[row * COLUMNS + c] = {colr, BLANK_CODE};
        end
    endtask

    // Move to column 0 of the next row; on the last row the grid scrolls up.
    task automatic line_feed();
        cur_col = '0;
        if (cur_row < ROWS - 1) begin
            cur_row++;
        end else begin
            for (int i = 0; i < CELLS - COLUMNS; i++) begin
                grid[i] = grid[i + COLUMNS];
            end
            blank_row(ROWS - 1, ink_color);
            scroll_count++;
        end
    endtask

    // A full row wraps before the character is stored.
    task automatic put_glyph(input logic [BYTE_W-1:0] ch);
        if (ch == NEWLINE_CODE) begin
            line_feed();
        end else begin
            if (cur_col >= COLUMNS) begin
                line_feed();
            end
            grid[cur_row * COLUMNS + cur_col] = {ink_color, ch};
            cur_col++;
        end
    endtask

    // Apply one item to the shadow console and build its result.
    task automatic console_apply(input t_item b, output t_result r);
        r = '0;
        case (b.operation)
            OP_PUT_CHAR: begin
                put_glyph(b.char_code);
            end
            OP_CLEAR: begin
                for (int row = 0; row < ROWS; row++) begin
                    blank_row(row, b.use_fill_color ? b.fill_color : ink_color);
                end
                cur_row = '0;
                cur_col = '0;
            end
            OP_SET_ROW: begin
                cur_row = (b.position > ROWS - 1) ? ROW_W'(ROWS - 1) : ROW_W'(b.position);
            end
            OP_SET_COL: begin
                cur_col = (b.position > COLUMNS - 1) ? COL_OUT_W'(COLUMNS - 1) : b.position;
            end
            OP_ERASE: begin
                if (cur_col > floor_col) begin
                    cur_col--;
                    grid[cur_row * COLUMNS + cur_col] = {ink_color, BLANK_CODE};
                end
            end
            OP_READ: begin
                if (b.cell_address < CELLS) begin
                    r.cell_char  = grid[b.cell_address][BYTE_W-1:0];
                    r.cell_color = grid[b.cell_address][CELL_W-1:BYTE_W];
                end
            end
            default: begin
                // Unused codes only report the cursor.
            end
        endcase
        r.cursor_row = cur_row;
        r.cursor_col = cur_col;
    endtask

    // Watch all three ports at every rising edge.
    always @(posedge i_clk) begin : watch
        t_item   beat;
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            for (int i = 0; i < CELLS; i++) begin
                grid[i] = '0;
            end
            cur_row   = '0;
            cur_col   = '0;
            ink_color = TEXT_COLOR_RST;
            floor_col = ERASE_FLOOR_RST;
            expected_results.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_TEXT_COLOR) begin
                    ink_color = i_cfg_data;
                end else begin
                    floor_col = i_cfg_data[POS_W-1:0];
                end
            end
            if (i_in_valid && !i_in_stall) begin
                beat = '{i_operation, i_char_code, i_use_fill_color, i_fill_color,
                         i_position, i_cell_address};
                console_apply(beat, want);
                expected_results.push_back(want);
            end
            if (i_out_valid && !i_out_stall) begin
                got = '{i_cell_char, i_cell_color, i_cursor_row, i_cursor_col};
                if (expected_results.size() == 0) begin
                    flag_error("result beat arrived with nothing expected");
                end else begin
                    want = expected_results.pop_front();
                    if (got.cell_char !== want.cell_char)
                        flag_error($sformatf("beat %0d cell_char got %0h want %0h",
                                             compared, got.cell_char, want.cell_char));
                    if (got.cell_color !== want.cell_color)
                        flag_error($sformatf("beat %0d cell_color got %0h want %0h",
                                             compared, got.cell_color, want.cell_color));
                    if (got.cursor_row !== want.cursor_row)
                        flag_error($sformatf("beat %0d cursor_row got %0d want %0d",
                                             compared, got.cursor_row, want.cursor_row));
                    if (got.cursor_col !== want.cursor_col)
                        flag_error($sformatf("beat %0d cursor_col got %0d want %0d",
                                             compared, got.cursor_col, want.cursor_col));
                end
                compared++;
            end
        end
        pending_n <= expected_results.size();
    end

endmodule

/* verif/text_console_writer_core_tb.sv */
// Testbench top for text_console_writer_core: clock, reset, item and register stimulus,
// result-side stalls and the verdict. Depends on tcw_pkg, the RTL and the checker.

module text_console_writer_core_tb;

    import tcw_pkg::*;

    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int PHASES      = 6;
    localparam int PHASE_BEATS = 320;
    localparam int HOLD_CYCLES = 300;

    // Codes 6 and 7 have no function in the block.
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              cfg_we    = 1'b0;
    logic              cfg_index = 1'b0;
    logic [BYTE_W-1:0] cfg_data  = '0;
    logic              in_valid  = 1'b0;
    logic              out_stall = 1'b0;
    t_item             beat_drv  = '0;

    logic                 in_stall;
    logic                 out_valid;
    logic [BYTE_W-1:0]    cell_char;
    logic [BYTE_W-1:0]    cell_color;
    logic [ROW_W-1:0]     cursor_row;
    logic [COL_OUT_W-1:0] cursor_col;

    int fail_count;
    int pending;
    int scrolls;
    int checked;

    // Stimulus state shared between the two sides.
    bit tx_idle  = 1'b1;
    bit rx_idle  = 1'b1;
    bit hold_req = 1'b0;
    int holds_done = 0;
    int beats_sent = 0;
    int op_count [8];
    int clears_left   = 16;
    int newlines_left = 150;
    int wraps_left    = 60;

    always #6 clk = ~clk;

    text_console_writer_core #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) uut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_operation      (beat_drv.operation),
        .i_char_code      (beat_drv.char_code),
        .i_use_fill_color (beat_drv.use_fill_color),
        .i_fill_color     (beat_drv.fill_color),
        .i_position       (beat_drv.position),
        .i_cell_address   (beat_drv.cell_address),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_cell_char      (cell_char),
        .o_cell_color     (cell_color),
        .o_cursor_row     (cursor_row),
        .o_cursor_col     (cursor_col)
    );

    text_console_writer_checker #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) console_check (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_operation      (beat_drv.operation),
        .i_char_code      (beat_drv.char_code),
        .i_use_fill_color (beat_drv.use_fill_color),
        .i_fill_color     (beat_drv.fill_color),
        .i_position       (beat_drv.position),
        .i_cell_address   (beat_drv.cell_address),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_cell_char      (cell_char),
        .i_cell_color     (cell_color),
        .i_cursor_row     (cursor_row),
        .i_cursor_col     (cursor_col),
        .o_fail_count     (fail_count),
        .o_pending        (pending),
        .o_scrolls        (scrolls),
        .o_checked        (checked)
    );

    // Every field random, so that unused fields toggle too.
    function automatic t_item random_beat();
        t_item b;
        b.operation      = OP_W'($urandom_range(0, 7));
        b.char_code      = BYTE_W'($urandom);
        b.use_fill_color = 1'($urandom);
        b.fill_color     = BYTE_W'($urandom);
        b.position       = POS_W'($urandom);
        b.cell_address   = ADDR_IN_W'($urandom);
        return b;
    endfunction

    // Keep slow operations within budget so the run length stays bounded.
    function automatic t_item tame(input t_item b);
        if (b.operation == OP_CLEAR) begin
            if (clears_left == 0) b.operation = OP_SPARE_HI;
            else clears_left--;
        end
        if (b.operation == OP_PUT_CHAR && b.char_code == NEWLINE_CODE) begin
            if (newlines_left == 0) b.char_code = BYTE_W'(NEWLINE_CODE + 1);
            else newlines_left--;
        end
        return b;
    endfunction

    // Offer one beat, optionally after a gap, and wait until it is taken.
    task automatic send_beat(input t_item b);
        int n;
        if (tx_idle && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 15);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
        @(negedge clk);
        beat_drv <= b;
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        beats_sent++;
        op_count[b.operation]++;
    endtask

    // One beat of a given operation; arg lands in the field that it uses.
    task automatic do_op(input logic [OP_W-1:0] op, input int arg);
        t_item b;
        b = random_beat();
        b.operation = op;
        case (op)
            OP_PUT_CHAR: b.char_code = BYTE_W'(arg);
            OP_SET_ROW,
            OP_SET_COL:  b.position = POS_W'(arg);
            OP_READ:     b.cell_address = ADDR_IN_W'(arg);
            OP_CLEAR: begin
                b.use_fill_color = arg[8];
                b.fill_color     = arg[7:0];
            end
            default: ;
        endcase
        send_beat(b);
    endtask

    task automatic put_text_char();
        int ch;
        if (newlines_left > 0 && $urandom_range(0, 9) == 0) begin
            ch = NEWLINE_CODE;
            newlines_left--;
        end else if ($urandom_range(0, 4) == 0) begin
            ch = $urandom_range(0, 255);
            if (ch == NEWLINE_CODE) ch = BLANK_CODE;
        end else begin
            ch = $urandom_range(33, 126);
        end
        do_op(OP_PUT_CHAR, ch);
    endtask

    task automatic write_reg(input logic idx, input logic [BYTE_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Drop valid and wait until every expected result has come back.
    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
    endtask

    // One short sequence of related operations, mostly well-formed text output.
    task automatic run_sequence();
        int k;
        int n;
        k = $urandom_range(0, 99);
        if (k < 55) begin
            // Position the cursor, then write a line fragment and look around.
            if ($urandom_range(0, 5) == 0)
                do_op(OP_SET_ROW, $urandom_range(0, 1) ? ROWS - 1 : $urandom_range(ROWS, 127));
            else
                do_op(OP_SET_ROW, $urandom_range(0, ROWS - 2));
            if ($urandom_range(0, 1)) do_op(OP_SET_COL, $urandom_range(0, 127));
            n = $urandom_range(1, 10);
            repeat (n) put_text_char();
            repeat ($urandom_range(0, 2)) do_op(OP_ERASE, 0);
            do_op(OP_READ, $urandom_range(0, 2047));
        end else if (k < 63 && wraps_left > 0) begin
            // Run past the end of a row.
            wraps_left--;
            do_op(OP_SET_COL, $urandom_range(COLUMNS - 4, 127));
            repeat ($urandom_range(2, 6)) put_text_char();
        end else if (k < 73) begin
            do_op(OP_SET_COL, $urandom_range(0, 127));
            repeat ($urandom_range(1, 8)) do_op(OP_ERASE, 0);
        end else if (k < 83) begin
            repeat ($urandom_range(1, 6)) begin
                n = $urandom_range(0, 19);
                if (n < 14) do_op(OP_READ, $urandom_range(0, ROWS * COLUMNS - 1));
                else if (n < 17) do_op(OP_READ, $urandom_range(ROWS * COLUMNS, 2047));
                else do_op(OP_READ, (n == 17) ? 0 : (n == 18) ? ROWS * COLUMNS - 1 : 2047);
            end
        end else if (k < 85 && clears_left > 0) begin
            clears_left--;
            do_op(OP_CLEAR, $urandom_range(0, 511));
        end else begin
            repeat ($urandom_range(1, 4)) send_beat(tame(random_beat()));
        end
    endtask

    // Result side: random stall bursts, free stretches and one long hold-off.
    initial begin : result_side
        int n;
        forever begin
            if (hold_req) begin
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                hold_req = 1'b0;
                holds_done++;
            end else if (rx_idle && $urandom_range(0, 2) == 0) begin
                n = $urandom_range(1, 15);
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (n - 1) @(negedge clk);
            end else begin
                n = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
                @(negedge clk);
                out_stall <= 1'b0;
                repeat (n - 1) @(negedge clk);
            end
        end
    end

    // Hard limit on the run.
    initial begin : watchdog
        #48_000_000;
        $display("timeout with %0d results outstanding", pending);
        $display("simulation failed");
        $finish;
    end

    // Main stimulus.
    initial begin : stimulus
        int phase_start;
        bit paused;
        paused = 1'b0;
        foreach (op_count[i]) op_count[i] = 0;
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part under the reset register values.
        do_op(OP_READ, 0);
        do_op(OP_READ, ROWS * COLUMNS);
        do_op(OP_READ, 2047);
        do_op(OP_PUT_CHAR, 8'h41);
        do_op(OP_PUT_CHAR, 8'hFF);
        do_op(OP_PUT_CHAR, 8'h00);
        do_op(OP_ERASE, 0);                      // column below the floor: no change
        do_op(OP_SET_COL, 127);                  // saturates to the last column
        do_op(OP_PUT_CHAR, 8'h5F);               // fills the row
        do_op(OP_PUT_CHAR, 8'h61);               // wraps to the next row
        do_op(OP_SET_COL, 10);
        do_op(OP_ERASE, 0);
        do_op(OP_READ, COLUMNS + 9);
        do_op(OP_SET_ROW, 127);                  // saturates to the last row
        do_op(OP_PUT_CHAR, 8'h5A);
        do_op(OP_PUT_CHAR, NEWLINE_CODE);        // newline on the last row scrolls
        do_op(OP_READ, (ROWS - 2) * COLUMNS + 9);
        do_op(OP_SET_COL, COLUMNS - 1);
        do_op(OP_PUT_CHAR, 8'h78);
        do_op(OP_PUT_CHAR, 8'h79);               // wrap on the last row scrolls
        do_op(OP_SPARE_LO, 0);
        do_op(OP_SPARE_HI, 0);
        do_op(OP_CLEAR, 9'h1A5);                 // clear with the fill color
        do_op(OP_READ, 1234);
        do_op(OP_CLEAR, 9'h000);                 // clear with the text color

        // Random phases, each under its own register setting.
        for (int phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            case (phase)
                0: begin
                    write_reg(CFG_ERASE_FLOOR, 8'd0);
                    write_reg(CFG_TEXT_COLOR, 8'h00);
                end
                1: begin
                    write_reg(CFG_ERASE_FLOOR, {1'($urandom), 7'd127});
                    write_reg(CFG_TEXT_COLOR, 8'hFF);
                end
                2: begin
                    write_reg(CFG_ERASE_FLOOR, BYTE_W'($urandom));
                    write_reg(CFG_TEXT_COLOR, BYTE_W'($urandom));
                end
                3: begin
                    write_reg(CFG_ERASE_FLOOR, 8'd79);
                    write_reg(CFG_TEXT_COLOR, BYTE_W'($urandom));
                end
                4: begin
                    write_reg(CFG_ERASE_FLOOR, 8'd80);
                    write_reg(CFG_TEXT_COLOR, BYTE_W'($urandom));
                end
                default: begin
                    write_reg(CFG_ERASE_FLOOR, BYTE_W'($urandom_range(0, 12)));
                    write_reg(CFG_TEXT_COLOR, BYTE_W'($urandom));
                    tx_idle = 1'b0;
                    rx_idle = 1'b0;
                end
            endcase
            phase_start = beats_sent;
            while (beats_sent - phase_start < PHASE_BEATS) begin
                if (phase == 2 && holds_done == 0 && !hold_req
                        && beats_sent - phase_start >= 100) begin
                    hold_req = 1'b1;
                end
                if (phase == 3 && !paused && beats_sent - phase_start >= 150) begin
                    wait_drained();
                    paused = 1'b1;
                end
                run_sequence();
            end
        end

        wait_drained();
        repeat (20) @(posedge clk);
        $display("Sent %0d beats: %0d writes, %0d clears, %0d row and %0d column moves,",
                 beats_sent, op_count[OP_PUT_CHAR], op_count[OP_CLEAR],
                 op_count[OP_SET_ROW], op_count[OP_SET_COL]);
        $display("%0d erases, %0d reads, %0d unused codes; %0d scrolls, %0d results compared.",
                 op_count[OP_ERASE], op_count[OP_READ],
                 op_count[OP_SPARE_LO] + op_count[OP_SPARE_HI], scrolls, checked);
        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
